### design/drl_pkg.sv
`default_nettype none

package drl_pkg;

	// intensity width, fixed by the pixel format
	localparam int VALUE_W = 12;

	// how a line is classified by the front end
	typedef struct packed {
		logic x_major;
		logic maj_neg;
		logic min_neg;
	} line_flags_t;

endpackage

`default_nettype wire

### design/drl_if.sv
`default_nettype none

// line request channel: two endpoints
interface line_if #(
	parameter int CW = 6
);
	logic          valid;
	logic          ready;
	logic [CW-1:0] start_x;
	logic [CW-1:0] start_y;
	logic [CW-1:0] end_x;
	logic [CW-1:0] end_y;

	modport source (output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// pixel write channel
interface pixel_if #(
	parameter int CW = 6
);
	logic                        valid;
	logic                        ready;
	logic [CW-1:0]               pixel_x;
	logic [CW-1:0]               pixel_y;
	logic [drl_pkg::VALUE_W-1:0] pixel_value;
	logic                        last;

	modport source (output valid, pixel_x, pixel_y, pixel_value, last, input ready);
	modport sink   (input valid, pixel_x, pixel_y, pixel_value, last, output ready);
endinterface

`default_nettype wire

### design/dda_line_rasterizer.sv
`default_nettype none

// channel     dir  handshake      payload
// line_in     in   valid/ready    start_x, start_y, end_x, end_y
// pixel_out   out  valid/ready    pixel_x, pixel_y, pixel_value, last
// cfg         in   cfg_we         cfg_wdata -> draw_value
//
// the back end loads a line, then runs the bit-serial slope divider, whose quotient
// has log2(IMAGE_SIZE) + FRAC_BITS bits (22 at the defaults), then steps out
// abs(delta_major) + 1 pixels; a line with equal endpoints skips the divider.
// the front stage and a two-entry queue take new lines while the back end draws.
// a stalled pixel output holds the stepper; reset clears all control state.

module dda_line_rasterizer #(
	parameter int IMAGE_SIZE = 64,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	line_if.sink                             line_in,
	pixel_if.source                          pixel_out,
	input  wire logic                        cfg_we,
	input  wire logic [drl_pkg::VALUE_W-1:0] cfg_wdata
);

	localparam int CW = $clog2(IMAGE_SIZE);
	localparam int LW = $bits(drl_pkg::line_flags_t) + 4 * CW;

	logic [drl_pkg::VALUE_W-1:0] draw_value_q;
	logic                        f_valid;
	logic                        f_ready;
	logic [LW-1:0]               f_data;
	logic                        b_valid;
	logic                        b_ready;
	logic [LW-1:0]               b_data;

	// intensity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_value_q <= '0;
		end else if (cfg_we) begin
			draw_value_q <= cfg_wdata;
		end
	end

	drl_front #(
		.CW (CW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.line_in    (line_in),
		.desc_valid (f_valid),
		.desc_ready (f_ready),
		.desc_data  (f_data)
	);

	drl_fifo #(
		.W (LW)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data)
	);

	drl_back #(
		.CW        (CW),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (b_valid),
		.desc_ready (b_ready),
		.desc_data  (b_data),
		.draw_value (draw_value_q),
		.pixel_out  (pixel_out)
	);

endmodule

`default_nettype wire

### design/drl_front.sv
`default_nettype none

module drl_front #(
	parameter int CW = 6,
	localparam int LW = $bits(drl_pkg::line_flags_t) + 4 * CW
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	line_if.sink               line_in,
	output logic               desc_valid,
	input  wire logic          desc_ready,
	output logic [LW-1:0]      desc_data
);

	logic                 dx_neg;
	logic                 dy_neg;
	logic [CW-1:0]        ax;
	logic [CW-1:0]        ay;
	drl_pkg::line_flags_t flags;
	logic [CW-1:0]        maj_start;
	logic [CW-1:0]        min_start;
	logic [CW-1:0]        amaj;
	logic [CW-1:0]        amin;
	logic                 valid_s1;
	logic [LW-1:0]        data_s1;

	// deltas as sign and magnitude
	always_comb begin
		dx_neg = line_in.end_x < line_in.start_x;
		dy_neg = line_in.end_y < line_in.start_y;
		ax = dx_neg ? line_in.start_x - line_in.end_x : line_in.end_x - line_in.start_x;
		ay = dy_neg ? line_in.start_y - line_in.end_y : line_in.end_y - line_in.start_y;
	end

	// pick the major axis, x wins a tie
	always_comb begin
		flags.x_major = ax >= ay;
		flags.maj_neg = flags.x_major ? dx_neg : dy_neg;
		flags.min_neg = flags.x_major ? dy_neg : dx_neg;
		maj_start = flags.x_major ? line_in.start_x : line_in.start_y;
		min_start = flags.x_major ? line_in.start_y : line_in.start_x;
		amaj = flags.x_major ? ax : ay;
		amin = flags.x_major ? ay : ax;
	end

	assign line_in.ready = !valid_s1 || desc_ready;

	// descriptor stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			data_s1 <= '0;
		end else if (line_in.ready) begin
			valid_s1 <= line_in.valid;
			if (line_in.valid) begin
				data_s1 <= {flags, maj_start, min_start, amaj, amin};
			end
		end
	end

	assign desc_valid = valid_s1;
	assign desc_data = data_s1;

endmodule

`default_nettype wire

### design/drl_fifo.sv
`default_nettype none

module drl_fifo #(
	parameter int W = 27
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push_valid,
	output logic              push_ready,
	input  wire logic [W-1:0] push_data,
	output logic              pop_valid,
	input  wire logic         pop_ready,
	output logic [W-1:0]      pop_data
);

	localparam int DEPTH = 2;
	localparam int PW = $clog2(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = count_q != (PW + 1)'(DEPTH);
	assign pop_valid = count_q != '0;
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (PW + 1)'(1);
				2'b01:   count_q <= count_q - (PW + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### design/drl_back.sv
`default_nettype none

module drl_back #(
	parameter int CW = 6,
	parameter int FRAC_BITS = 16,
	localparam int LW = $bits(drl_pkg::line_flags_t) + 4 * CW
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        desc_valid,
	output logic                             desc_ready,
	input  wire logic [LW-1:0]               desc_data,
	input  wire logic [drl_pkg::VALUE_W-1:0] draw_value,
	pixel_if.source                          pixel_out
);

	localparam int DW = CW + FRAC_BITS;
	localparam int NW = $clog2(DW + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_RUN} state_t;

	state_t                state_q;
	drl_pkg::line_flags_t  d_flags;
	logic [CW-1:0]         d_maj;
	logic [CW-1:0]         d_min;
	logic [CW-1:0]         d_amaj;
	logic [CW-1:0]         d_amin;
	drl_pkg::line_flags_t  flags_q;
	logic [CW-1:0]         maj_q;
	logic [DW-1:0]         pos_q;
	logic [DW-1:0]         step_q;
	logic [CW-1:0]         left_q;
	logic [DW-1:0]         quo_q;
	logic [CW-1:0]         rem_q;
	logic [CW-1:0]         div_q;
	logic [NW-1:0]         cnt_q;
	logic [CW:0]           trial;
	logic [CW:0]           diff;
	logic                  ge;
	logic [CW-1:0]         rem_next;
	logic [DW-1:0]         quo_next;
	logic                  out_free;
	logic                  ovalid_q;
	logic [CW-1:0]         px_q;
	logic [CW-1:0]         py_q;
	logic [drl_pkg::VALUE_W-1:0] pval_q;
	logic                  last_q;

	assign {d_flags, d_maj, d_min, d_amaj, d_amin} = desc_data;
	assign desc_ready = state_q == ST_IDLE;
	assign out_free = !ovalid_q || pixel_out.ready;

	// one restoring division step per cycle
	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		diff = trial - {1'b0, div_q};
		ge = trial >= {1'b0, div_q};
		rem_next = ge ? diff[CW-1:0] : trial[CW-1:0];
		quo_next = {quo_q[DW-2:0], ge};
	end

	// sequencer, slope divider, stepper and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			flags_q <= '0;
			maj_q <= '0;
			pos_q <= '0;
			step_q <= '0;
			left_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			div_q <= '0;
			cnt_q <= '0;
			ovalid_q <= 1'b0;
			px_q <= '0;
			py_q <= '0;
			pval_q <= '0;
			last_q <= 1'b0;
		end else begin
			// output register fills on a new pixel and drains when taken
			if (state_q == ST_RUN && out_free) begin
				ovalid_q <= 1'b1;
			end else if (pixel_out.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (desc_valid) begin
						flags_q <= d_flags;
						maj_q <= d_maj;
						pos_q <= {d_min, FRAC_BITS'(0)};
						step_q <= '0;
						left_q <= d_amaj;
						quo_q <= {d_amin, FRAC_BITS'(0)};
						rem_q <= '0;
						div_q <= d_amaj;
						cnt_q <= NW'(DW);
						// a single point needs no slope
						state_q <= (d_amaj == '0) ? ST_RUN : ST_DIV;
					end
				end
				ST_DIV: begin
					quo_q <= quo_next;
					rem_q <= rem_next;
					cnt_q <= cnt_q - NW'(1);
					if (cnt_q == NW'(1)) begin
						step_q <= flags_q.min_neg ? (~quo_next + DW'(1)) : quo_next;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (out_free) begin
						px_q <= flags_q.x_major ? maj_q : pos_q[DW-1:FRAC_BITS];
						py_q <= flags_q.x_major ? pos_q[DW-1:FRAC_BITS] : maj_q;
						pval_q <= draw_value;
						last_q <= left_q == '0;
						maj_q <= flags_q.maj_neg ? maj_q - CW'(1) : maj_q + CW'(1);
						pos_q <= pos_q + step_q;
						left_q <= left_q - CW'(1);
						if (left_q == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign pixel_out.valid = ovalid_q;
	assign pixel_out.pixel_x = px_q;
	assign pixel_out.pixel_y = py_q;
	assign pixel_out.pixel_value = pval_q;
	assign pixel_out.last = last_q;

endmodule

`default_nettype wire
